// ===== rtl/core/voltage_table_interpolator_assert.svh =====
// assertion macros for the voltage table interpolator port checker
// expects clk and rst_n in the scope where a macro is used
`ifndef VOLTAGE_TABLE_INTERPOLATOR_ASSERT_SVH
`define VOLTAGE_TABLE_INTERPOLATOR_ASSERT_SVH

// condition implies a consequence in the same cycle
`define VTI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies a consequence in the following cycle
`define VTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/vti_pkg.sv =====
// shared types, constants and helpers of the voltage table interpolator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package vti_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int ROW_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int REQ_W     = 1;
  localparam int IDX_W     = 6;
  localparam int VOLT_W    = 25;
  localparam int CAP_W     = 10;
  localparam int QTY_W     = 31;
  localparam int BUS_W     = 15;
  localparam int SEL_W     = 2;
  localparam int VALUE_W   = 32;
  localparam int CASE_W    = 2;
  localparam int CFG_LEN_W = 7;

  // input tdata layout, lowest field first
  localparam int F_ROW_INDEX_LSB = 0;
  localparam int F_VOLTAGE_LSB   = F_ROW_INDEX_LSB + IDX_W;
  localparam int F_CAPACITY_LSB  = F_VOLTAGE_LSB + VOLT_W;
  localparam int F_CHARGE_LSB    = F_CAPACITY_LSB + CAP_W;
  localparam int F_ENERGY_LSB    = F_CHARGE_LSB + QTY_W;
  localparam int F_BUS_LSB       = F_ENERGY_LSB + QTY_W;
  localparam int F_SEL_LSB       = F_BUS_LSB + BUS_W;
  localparam int IN_FIELDS_W     = F_SEL_LSB + SEL_W;
  localparam int IN_TDATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W     = VALUE_W;

  // interpolation arithmetic
  localparam int PROD_W    = VOLT_W + QTY_W;
  localparam int DIV_STEPS = QTY_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_TABLE_LENGTH = '0;

  // constants
  localparam logic [VOLT_W-1:0]  UV_PER_MV        = VOLT_W'(1000);
  localparam logic [VALUE_W-1:0] DEFAULT_CAPACITY = VALUE_W'(500);

  // request kinds carried in tuser
  localparam logic [REQ_W-1:0] REQ_WRITE  = 1'b0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 1'b1;

  // quantity selector codes
  localparam logic [SEL_W-1:0] QTY_CAPACITY = 2'd0;
  localparam logic [SEL_W-1:0] QTY_CHARGE   = 2'd1;
  localparam logic [SEL_W-1:0] QTY_ENERGY   = 2'd2;

  typedef enum logic [CASE_W-1:0] {
    CASE_EMPTY  = 2'd0,
    CASE_TOP    = 2'd1,
    CASE_BOTTOM = 2'd2,
    CASE_INTERP = 2'd3
  } lookup_case_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP,
    ST_BOT,
    ST_SRCH,
    ST_LO,
    ST_HI,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_FIN
  } seq_state_t;

  // one table row
  typedef struct packed {
    logic [VOLT_W-1:0] voltage;
    logic [CAP_W-1:0]  capacity;
    logic [QTY_W-1:0]  charge;
    logic [QTY_W-1:0]  energy;
  } row_t;

  // table port control from the sequencer
  typedef struct packed {
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    row_t             wr_row;
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
  } table_cmd_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [VOLT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quotient;
  } div_rsp_t;

  // selected quantity of a row, zero for the unused selector code
  function automatic logic [QTY_W-1:0] qty_of(input row_t row, input logic [SEL_W-1:0] sel);
    logic [QTY_W-1:0] q;
    unique case (sel)
      QTY_CAPACITY: q = QTY_W'(row.capacity);
      QTY_CHARGE:   q = row.charge;
      QTY_ENERGY:   q = row.energy;
      default:      q = '0;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vti_table.sv =====
// row memory of the voltage table: one write port, one registered read port
// depends on vti_pkg for the row and port types
`timescale 1ns / 1ps
`default_nettype none

module vti_table (
  input  logic                clk,
  input  vti_pkg::table_cmd_t cmd,
  output vti_pkg::row_t       rd_row
);
  import vti_pkg::*;

  row_t mem [TABLE_DEPTH];
  row_t rd_row_r;

  // row write
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_row;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_row_r <= mem[cmd.rd_addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

`default_nettype wire

// ===== rtl/core/vti_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on vti_pkg; quotient must fit DIV_STEPS bits (remainder head below divisor)
`timescale 1ns / 1ps
`default_nettype none

module vti_div (
  input  logic              clk,
  input  logic              rst_n,
  input  vti_pkg::div_req_t req,
  output vti_pkg::div_rsp_t rsp
);
  import vti_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [VOLT_W-1:0]    rem_r;
  logic [VOLT_W-1:0]    dvs_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic [VOLT_W:0]      trial;
  logic [VOLT_W:0]      diff;
  logic                 fits;

  // trial subtract of the shifted partial remainder
  assign trial = {rem_r, quo_r[DIV_STEPS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + DIV_CNT_W'(1);
        end
      end
    end
  end

  // remainder and quotient shift register; dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[PROD_W-1 -: VOLT_W];
      quo_r <= req.dividend[DIV_STEPS-1:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[VOLT_W-1:0] : trial[VOLT_W-1:0];
      quo_r <= {quo_r[DIV_STEPS-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/vti_seq.sv =====
// lookup sequencer: stream handshake, clamp checks, binary search over the
// table port, interpolation setup and result register; depends on vti_pkg
`timescale 1ns / 1ps
`default_nettype none

module vti_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vti_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [vti_pkg::REQ_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vti_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [vti_pkg::CASE_W-1:0]        out_tuser,
  input  logic [vti_pkg::CFG_LEN_W-1:0]     table_length,
  output vti_pkg::table_cmd_t               tbl_cmd,
  input  vti_pkg::row_t                     rd_row,
  output vti_pkg::div_req_t                 div_req,
  input  vti_pkg::div_rsp_t                 div_rsp
);
  import vti_pkg::*;

  seq_state_t state_r, state_nxt;

  // input fields
  logic [IDX_W-1:0]  f_row_index;
  logic [VOLT_W-1:0] f_voltage;
  logic [CAP_W-1:0]  f_capacity;
  logic [QTY_W-1:0]  f_charge;
  logic [QTY_W-1:0]  f_energy;
  logic [BUS_W-1:0]  f_bus;
  logic [SEL_W-1:0]  f_sel;

  logic              in_acc;
  logic              row_in_range;
  logic [LEN_W-1:0]  len_eff;
  logic [ROW_W-1:0]  last_row;

  // lookup working registers
  logic [VOLT_W-1:0]  bus_uv_r;
  logic [SEL_W-1:0]   sel_r;
  logic [LEN_W-1:0]   len_r;
  logic [ROW_W-1:0]   lo_r, hi_r, mid_r;
  logic [VOLT_W-1:0]  vlo_r;
  logic [QTY_W-1:0]   qlo_r;
  logic [VOLT_W-1:0]  a_r;
  logic [VOLT_W-1:0]  e_r;
  logic [QTY_W-1:0]   mag_r;
  logic               neg_r;
  logic [PROD_W-1:0]  prod_r;
  logic [VALUE_W-1:0] res_value_r;
  lookup_case_t       res_case_r;

  // result register
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  lookup_case_t       out_case_r;
  logic               load_out;

  // search step
  logic [ROW_W-1:0] lo_nxt, hi_nxt, mid_nxt, span, search_addr;
  logic [ROW_W:0]   mid_sum;
  logic             more;
  logic             go_hi;
  logic [QTY_W-1:0] rd_q;

  assign f_row_index = in_tdata[F_ROW_INDEX_LSB +: IDX_W];
  assign f_voltage   = in_tdata[F_VOLTAGE_LSB +: VOLT_W];
  assign f_capacity  = in_tdata[F_CAPACITY_LSB +: CAP_W];
  assign f_charge    = in_tdata[F_CHARGE_LSB +: QTY_W];
  assign f_energy    = in_tdata[F_ENERGY_LSB +: QTY_W];
  assign f_bus       = in_tdata[F_BUS_LSB +: BUS_W];
  assign f_sel       = in_tdata[F_SEL_LSB +: SEL_W];

  assign in_tready    = (state_r == ST_IDLE);
  assign in_acc       = in_tvalid && in_tready;
  assign row_in_range = (int'(f_row_index) < TABLE_DEPTH);
  assign len_eff      = (int'(table_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                           : LEN_W'(table_length);
  assign last_row     = ROW_W'(len_r - LEN_W'(1));
  assign rd_q         = qty_of(rd_row, sel_r);
  assign go_hi        = (bus_uv_r > rd_row.voltage);

  // bracket update: start from the end rows, then halve
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (state_r == ST_BOT) begin
      lo_nxt = '0;
      hi_nxt = last_row;
    end else if (state_r == ST_SRCH) begin
      if (go_hi) begin
        hi_nxt = mid_r;
      end else begin
        lo_nxt = mid_r;
      end
    end
  end

  assign span        = hi_nxt - lo_nxt;
  assign more        = (span > ROW_W'(1));
  assign mid_sum     = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mid_nxt     = mid_sum[ROW_W:1];
  assign search_addr = more ? mid_nxt : lo_nxt;

  // next state and port control
  always_comb begin
    state_nxt = state_r;
    tbl_cmd   = '0;
    div_req   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == REQ_WRITE) begin
            tbl_cmd.wr_en           = row_in_range;
            tbl_cmd.wr_addr         = ROW_W'(f_row_index);
            tbl_cmd.wr_row.voltage  = f_voltage;
            tbl_cmd.wr_row.capacity = f_capacity;
            tbl_cmd.wr_row.charge   = f_charge;
            tbl_cmd.wr_row.energy   = f_energy;
          end else if (len_eff == '0) begin
            state_nxt = ST_FIN;
          end else begin
            tbl_cmd.rd_en   = 1'b1;
            tbl_cmd.rd_addr = '0;
            state_nxt       = ST_TOP;
          end
        end
      end
      ST_TOP: begin
        if (bus_uv_r >= rd_row.voltage) begin
          state_nxt = ST_FIN;
        end else begin
          tbl_cmd.rd_en   = 1'b1;
          tbl_cmd.rd_addr = last_row;
          state_nxt       = ST_BOT;
        end
      end
      ST_BOT: begin
        if (bus_uv_r <= rd_row.voltage) begin
          state_nxt = ST_FIN;
        end else begin
          tbl_cmd.rd_en   = 1'b1;
          tbl_cmd.rd_addr = search_addr;
          state_nxt       = more ? ST_SRCH : ST_LO;
        end
      end
      ST_SRCH: begin
        tbl_cmd.rd_en   = 1'b1;
        tbl_cmd.rd_addr = search_addr;
        state_nxt       = more ? ST_SRCH : ST_LO;
      end
      ST_LO: begin
        tbl_cmd.rd_en   = 1'b1;
        tbl_cmd.rd_addr = hi_r;
        state_nxt       = ST_HI;
      end
      ST_HI: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        // dividend carries the half-divisor bias for round to nearest
        div_req.start    = 1'b1;
        div_req.dividend = prod_r + PROD_W'(e_r >> 1);
        div_req.divisor  = e_r;
        state_nxt        = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // lookup datapath; both end rows bracket the voltage strictly, so the
  // interpolation runs on magnitudes with vlo >= bus > vhi
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == REQ_LOOKUP)) begin
          bus_uv_r    <= f_bus * UV_PER_MV;
          sel_r       <= f_sel;
          len_r       <= len_eff;
          res_case_r  <= CASE_EMPTY;
          res_value_r <= (f_sel == QTY_CAPACITY) ? DEFAULT_CAPACITY : '0;
        end
      end
      ST_TOP: begin
        res_case_r  <= CASE_TOP;
        res_value_r <= {1'b0, rd_q};
      end
      ST_BOT: begin
        res_case_r  <= CASE_BOTTOM;
        res_value_r <= {1'b0, rd_q};
        lo_r        <= lo_nxt;
        hi_r        <= hi_nxt;
        mid_r       <= mid_nxt;
      end
      ST_SRCH: begin
        lo_r  <= lo_nxt;
        hi_r  <= hi_nxt;
        mid_r <= mid_nxt;
      end
      ST_LO: begin
        vlo_r <= rd_row.voltage;
        qlo_r <= rd_q;
      end
      ST_HI: begin
        a_r   <= vlo_r - bus_uv_r;
        e_r   <= vlo_r - rd_row.voltage;
        neg_r <= (rd_q < qlo_r);
        mag_r <= (rd_q < qlo_r) ? (qlo_r - rd_q) : (rd_q - qlo_r);
      end
      ST_MUL: begin
        prod_r <= a_r * mag_r;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_case_r  <= CASE_INTERP;
          res_value_r <= neg_r ? ({1'b0, qlo_r} - {1'b0, div_rsp.quotient})
                               : ({1'b0, qlo_r} + {1'b0, div_rsp.quotient});
        end
      end
      default: ;
    endcase
  end

  // output register
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= res_value_r;
      out_case_r  <= res_case_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_case_r;

endmodule

`default_nettype wire

// ===== rtl/core/voltage_table_interpolator.sv =====
// top level of the voltage table interpolator: register port, row memory,
// lookup sequencer and serial divider; depends on vti_pkg, vti_table, vti_seq, vti_div
//
//  channel   kind          payload
//  in_*      stream slave  tuser: req_type; tdata: row and lookup fields
//  out_*     stream master tuser: lookup_case; tdata: value
//  p*        apb slave     table_length at byte address 0
//
// a row write leaves the block idle; a lookup on an empty table goes straight
// to its result, a top clamp ends after the top row read, a bottom clamp after
// the bottom row read, and an interpolated lookup runs a binary search over the
// single table read port, then the serial divider at one quotient bit per cycle.
// reset is synchronous: it clears the sequencer, the result valid and
// table_length, and leaves the table rows as they are.
// a finished result sits in the output register; the next item is accepted
// meanwhile, and a later lookup waits at its end until that register frees.
`timescale 1ns / 1ps
`default_nettype none

module voltage_table_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: row_index, row_voltage_uv, row_capacity, row_charge, row_energy,
  //        bus_voltage_mv, quantity_select
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vti_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [vti_pkg::REQ_W-1:0]         in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vti_pkg::OUT_TDATA_W-1:0]   out_tdata,  // value
  output logic [vti_pkg::CASE_W-1:0]        out_tuser,  // lookup_case
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vti_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [vti_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [vti_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import vti_pkg::*;

  logic [CFG_LEN_W-1:0] table_length_r;
  logic                 reg_hit;
  logic                 reg_wr;
  table_cmd_t           tbl_cmd;
  row_t                 rd_row;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // register decode on word address
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_TABLE_LENGTH);
  assign reg_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_hit ? APB_DATA_W'(table_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (reg_wr && reg_hit) begin
      table_length_r <= pwdata[CFG_LEN_W-1:0];
    end
  end

  vti_table u_table (
    .clk    (clk),
    .cmd    (tbl_cmd),
    .rd_row (rd_row)
  );

  vti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  vti_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .table_length (table_length_r),
    .tbl_cmd      (tbl_cmd),
    .rd_row       (rd_row),
    .div_req      (div_req),
    .div_rsp      (div_rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/core/vti_checker.sv =====
// port-level checker of the voltage table interpolator and its bind
// depends on vti_pkg and voltage_table_interpolator_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "voltage_table_interpolator_assert.svh"

module vti_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [vti_pkg::REQ_W-1:0]         in_tuser,   // req_type
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [vti_pkg::OUT_TDATA_W-1:0]   out_tdata,  // value
  input  logic [vti_pkg::CASE_W-1:0]        out_tuser   // lookup_case
);
  import vti_pkg::*;

  logic lookup_xfer;
  logic write_xfer;

  assign lookup_xfer = in_tvalid && in_tready && (in_tuser == REQ_LOOKUP);
  assign write_xfer  = in_tvalid && in_tready && (in_tuser == REQ_WRITE);

  // a stalled result holds still
  `VTI_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  // after a lookup transfer the block is busy and input ready drops
  `VTI_ASSERT_NEXT(a_lookup_busy, lookup_xfer, !in_tready, "ready right after a lookup transfer")
  // row writes never stall the input side
  `VTI_ASSERT_NEXT(a_write_ready, write_xfer, in_tready, "not ready after a row write")
  // empty table yields only the fixed defaults
  `VTI_ASSERT_SAME(a_empty_value, out_tvalid && (out_tuser == CASE_EMPTY), (out_tdata == DEFAULT_CAPACITY) || (out_tdata == '0), "bad empty-table default")
  // quantities are never negative
  `VTI_ASSERT_SAME(a_value_sign, out_tvalid, !out_tdata[VALUE_W-1], "negative result value")

endmodule

bind voltage_table_interpolator vti_checker u_vti_checker (.*);

`default_nettype wire

// ===== sim/voltage_table_interpolator_tb.sv =====
// self-checking testbench for the voltage table interpolator: loads table rows,
// sets table_length over the register port and checks every lookup result
// depends on vti_pkg and the voltage_table_interpolator top level
`timescale 1ns / 1ps

module voltage_table_interpolator_tb;
  import vti_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int TOTAL_ITEMS   = 1350;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_LIMIT   = 40;
  localparam int VOLT_TOP      = (1 << VOLT_W) - 1;
  localparam int BUS_TOP       = (1 << BUS_W) - 1;
  localparam logic [SEL_W-1:0]      QTY_UNUSED        = 2'd3;
  localparam logic [APB_ADDR_W-1:0] ADDR_TABLE_LENGTH = {REG_TABLE_LENGTH, 2'b00};

  typedef enum logic [1:0] {STEP_ROW, STEP_LOOKUP, STEP_LENGTH} step_kind_t;

  // one directed step; exp_* only used where known is set
  typedef struct packed {
    step_kind_t           kind;
    logic [IDX_W-1:0]     row;
    logic [VOLT_W-1:0]    volt;
    logic [CAP_W-1:0]     cap;
    logic [QTY_W-1:0]     chg;
    logic [QTY_W-1:0]     nrg;
    logic [BUS_W-1:0]     bus;
    logic [SEL_W-1:0]     sel;
    logic [CFG_LEN_W-1:0] len;
    logic                 known;
    logic [VALUE_W-1:0]   exp_value;
    lookup_case_t         exp_case;
  } step_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    lookup_case_t       kind;
  } reading_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [REQ_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [CASE_W-1:0] out_tuser;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // predictor copy of the table and the length register
  logic [VOLT_W-1:0]    volt_col   [TABLE_DEPTH];
  logic [CAP_W-1:0]     cap_col    [TABLE_DEPTH];
  logic [QTY_W-1:0]     charge_col [TABLE_DEPTH];
  logic [QTY_W-1:0]     energy_col [TABLE_DEPTH];
  logic [CFG_LEN_W-1:0] length_reg = '0;

  reading_t    readings_due [$];
  reading_t    due_reading;
  reading_t    known_reading;
  bit          known_valid     = 1'b0;
  bit          source_calm     = 1'b0;
  bit          sink_calm       = 1'b0;
  int unsigned sink_hold       = 0;
  int unsigned sink_roll;
  int unsigned cycles          = 0;
  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned rows_sent       = 0;
  int unsigned lookups_sent    = 0;
  int unsigned lengths_set     = 0;

  // directed steps: empty table, clamps, interpolation, rounding tie, odd selector
  step_t directed_steps [24] = '{
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd0, QTY_CAPACITY, 7'd0,
      1'b1, 32'd500, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd32767, QTY_CHARGE, 7'd0,
      1'b1, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd16384, QTY_ENERGY, 7'd0,
      1'b1, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd21845, QTY_UNUSED, 7'd0,
      1'b1, 32'd0, CASE_EMPTY},
    // four descending rows with field extremes
    '{STEP_ROW, 6'd0, 25'd30000000, 10'd1000, 31'h7FFFFFFF, 31'h7FFFFFFF, 15'd0,
      QTY_CAPACITY, 7'd0, 1'b0, 32'd0, CASE_EMPTY},
    '{STEP_ROW, 6'd1, 25'd20000000, 10'd600, 31'd1000000, 31'd5, 15'd0,
      QTY_CAPACITY, 7'd0, 1'b0, 32'd0, CASE_EMPTY},
    '{STEP_ROW, 6'd2, 25'd10000000, 10'd101, 31'd0, 31'h7FFFFFFF, 15'd0,
      QTY_CAPACITY, 7'd0, 1'b0, 32'd0, CASE_EMPTY},
    '{STEP_ROW, 6'd3, 25'd0, 10'd0, 31'd0, 31'd0, 15'd0,
      QTY_CAPACITY, 7'd0, 1'b0, 32'd0, CASE_EMPTY},
    // single row: only clamps possible
    '{STEP_LENGTH, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd0, QTY_CAPACITY, 7'd1,
      1'b0, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd30000, QTY_CAPACITY, 7'd0,
      1'b1, 32'd1000, CASE_TOP},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd29999, QTY_CHARGE, 7'd0,
      1'b1, 32'h7FFFFFFF, CASE_BOTTOM},
    '{STEP_LENGTH, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd0, QTY_CAPACITY, 7'd4,
      1'b0, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd32767, QTY_ENERGY, 7'd0,
      1'b1, 32'h7FFFFFFF, CASE_TOP},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd0, QTY_CAPACITY, 7'd0,
      1'b1, 32'd0, CASE_BOTTOM},
    // rounding tie between rows 1 and 2, exact hit on row 1, steep slopes
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd15000, QTY_CAPACITY, 7'd0,
      1'b0, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd20000, QTY_CHARGE, 7'd0,
      1'b0, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd25000, QTY_ENERGY, 7'd0,
      1'b0, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd5000, QTY_ENERGY, 7'd0,
      1'b0, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd12345, QTY_UNUSED, 7'd0,
      1'b1, 32'd0, CASE_INTERP},
    // top row at full scale, then two equal voltages
    '{STEP_ROW, 6'd0, 25'h1FFFFFF, 10'd1000, 31'd0, 31'd0, 15'd0,
      QTY_CAPACITY, 7'd0, 1'b0, 32'd0, CASE_EMPTY},
    '{STEP_LENGTH, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd0, QTY_CAPACITY, 7'd2,
      1'b0, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd32767, QTY_CHARGE, 7'd0,
      1'b0, 32'd0, CASE_EMPTY},
    '{STEP_ROW, 6'd1, 25'h1FFFFFF, 10'd7, 31'd3, 31'd9, 15'd0,
      QTY_CAPACITY, 7'd0, 1'b0, 32'd0, CASE_EMPTY},
    '{STEP_LOOKUP, 6'd0, 25'd0, 10'd0, 31'd0, 31'd0, 15'd100, QTY_CAPACITY, 7'd0,
      1'b1, 32'd7, CASE_BOTTOM}
  };

  voltage_table_interpolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, readings_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic longint column_qty(logic [SEL_W-1:0] sel, int unsigned row);
    case (sel)
      QTY_CAPACITY: return longint'(cap_col[row]);
      QTY_CHARGE:   return longint'(charge_col[row]);
      QTY_ENERGY:   return longint'(energy_col[row]);
      default:      return 0;
    endcase
  endfunction

  // expected reading for a lookup against the current table
  function automatic reading_t gauge_reading(logic [BUS_W-1:0] bus_mv, logic [SEL_W-1:0] sel);
    reading_t          r;
    longint            bus_uv;
    longint            num;
    longint            den;
    longint            share;
    longint unsigned   mag_n;
    longint unsigned   mag_d;
    int unsigned       rows;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mid;
    bus_uv = longint'(bus_mv) * longint'(UV_PER_MV);
    rows = (int'(length_reg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_reg);
    if (rows == 0) begin
      r.kind  = CASE_EMPTY;
      r.value = (sel == QTY_CAPACITY) ? DEFAULT_CAPACITY : '0;
    end else if (bus_uv >= longint'(volt_col[0])) begin
      r.kind  = CASE_TOP;
      r.value = VALUE_W'(column_qty(sel, 0));
    end else if (bus_uv <= longint'(volt_col[rows - 1])) begin
      r.kind  = CASE_BOTTOM;
      r.value = VALUE_W'(column_qty(sel, rows - 1));
    end else begin
      // search keeps v[lo] >= bus > v[hi]
      lo = 0;
      hi = rows - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (bus_uv > longint'(volt_col[mid])) hi = mid;
        else lo = mid;
      end
      num = (bus_uv - longint'(volt_col[lo])) * (column_qty(sel, hi) - column_qty(sel, lo));
      den = longint'(volt_col[hi]) - longint'(volt_col[lo]);
      // round half away from zero on magnitudes
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      share = $signed((mag_n + mag_d / 2) / mag_d);
      if ((num < 0) != (den < 0)) share = -share;
      r.kind  = CASE_INTERP;
      r.value = VALUE_W'(column_qty(sel, lo) + share);
    end
    return r;
  endfunction

  // input transfers: update the table or queue the expected reading
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == REQ_WRITE) begin
        volt_col[in_tdata[F_ROW_INDEX_LSB +: IDX_W]]   = in_tdata[F_VOLTAGE_LSB +: VOLT_W];
        cap_col[in_tdata[F_ROW_INDEX_LSB +: IDX_W]]    = in_tdata[F_CAPACITY_LSB +: CAP_W];
        charge_col[in_tdata[F_ROW_INDEX_LSB +: IDX_W]] = in_tdata[F_CHARGE_LSB +: QTY_W];
        energy_col[in_tdata[F_ROW_INDEX_LSB +: IDX_W]] = in_tdata[F_ENERGY_LSB +: QTY_W];
      end else if (known_valid) begin
        readings_due.push_back(known_reading);
      end else begin
        readings_due.push_back(gauge_reading(in_tdata[F_BUS_LSB +: BUS_W],
                                             in_tdata[F_SEL_LSB +: SEL_W]));
      end
    end
  end

  // register writes seen on the config port
  always @(posedge clk) begin
    if (rst_n && psel && penable && pwrite && pready && paddr == ADDR_TABLE_LENGTH) begin
      length_reg <= pwdata[CFG_LEN_W-1:0];
    end
  end

  // result transfers against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (readings_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: value %0d case %0d",
                                  $signed(out_tdata), out_tuser));
      end else begin
        due_reading = readings_due.pop_front();
        results_checked++;
        if (out_tdata !== due_reading.value)
          report_mismatch($sformatf("value %0d, expected %0d (case %0d)", $signed(out_tdata),
                                    $signed(due_reading.value), due_reading.kind));
        if (out_tuser !== due_reading.kind)
          report_mismatch($sformatf("lookup_case %0d, expected %0d", out_tuser,
                                    due_reading.kind));
      end
    end
  end

  // result side back-pressure: mostly ready, short stalls, a few long ones
  always @(negedge clk) begin
    if (sink_hold != 0) begin
      sink_hold--;
      out_tready <= 1'b0;
    end else if (sink_calm) begin
      out_tready <= 1'b1;
    end else begin
      sink_roll = $urandom_range(99);
      if (sink_roll < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        sink_hold = (sink_roll < 95) ? $urandom_range(2) : $urandom_range(40, 10);
      end
    end
  end

  function automatic int unsigned gap_cycles();
    int unsigned roll;
    if (source_calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(50, 10);
  endfunction

  function automatic logic [QTY_W-1:0] random_qty();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return QTY_W'($urandom);
  endfunction

  // one input transfer, after an optional idle gap
  task automatic send_item(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] row,
                           logic [VOLT_W-1:0] volt, logic [CAP_W-1:0] cap,
                           logic [QTY_W-1:0] chg, logic [QTY_W-1:0] nrg,
                           logic [BUS_W-1:0] bus, logic [SEL_W-1:0] sel,
                           bit known, logic [VALUE_W-1:0] exp_value, lookup_case_t exp_case);
    int unsigned gap;
    gap = gap_cycles();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    known_valid         = known;
    known_reading.value = exp_value;
    known_reading.kind  = exp_case;
    in_tuser  <= kind;
    in_tdata  <= IN_TDATA_W'({sel, bus, nrg, chg, cap, volt, row});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == REQ_LOOKUP) lookups_sent++;
    else rows_sent++;
  endtask

  task automatic send_row(logic [IDX_W-1:0] row, logic [VOLT_W-1:0] volt);
    send_item(REQ_WRITE, row, volt, CAP_W'($urandom_range(1000)), random_qty(), random_qty(),
              BUS_W'($urandom), SEL_W'($urandom), 1'b0, '0, CASE_EMPTY);
  endtask

  task automatic send_lookup(logic [BUS_W-1:0] bus, logic [SEL_W-1:0] sel);
    send_item(REQ_LOOKUP, IDX_W'($urandom), VOLT_W'($urandom), CAP_W'($urandom_range(1000)),
              random_qty(), random_qty(), bus, sel, 1'b0, '0, CASE_EMPTY);
  endtask

  // hold the sender until every result is back and the block is idle
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write table_length while idle, then read it back
  task automatic set_table_length(logic [CFG_LEN_W-1:0] len);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TABLE_LENGTH;
    pwdata  <= APB_DATA_W'(len);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DATA_W'(len))
      report_mismatch($sformatf("table_length reads %0d, expected %0d", prdata, len));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    lengths_set++;
  endtask

  initial begin
    step_t       step;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned rows;
    int unsigned roll;
    int unsigned bus_mv;
    int unsigned v;
    int unsigned idx;
    int unsigned style;
    int unsigned lookups;
    int unsigned volt_pool [$];

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_WRITE;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_steps[i]) begin
      step = directed_steps[i];
      case (step.kind)
        STEP_LENGTH: set_table_length(step.len);
        STEP_ROW: begin
          send_item(REQ_WRITE, step.row, step.volt, step.cap, step.chg, step.nrg, step.bus,
                    step.sel, 1'b0, '0, CASE_EMPTY);
        end
        default: begin
          send_item(REQ_LOOKUP, step.row, step.volt, step.cap, step.chg, step.nrg, step.bus,
                    step.sel, step.known, step.exp_value, step.exp_case);
        end
      endcase
    end

    // random phases: load rows, set the length, then lookups with some noise
    phase = 0;
    while (rows_sent + lookups_sent < TOTAL_ITEMS) begin
      roll = $urandom_range(99);
      if (phase == 0) phase_len = 127;
      else if (phase == 1) phase_len = 0;
      else if (phase == 2) phase_len = TABLE_DEPTH;
      else if (roll < 10) phase_len = 0;
      else if (roll < 22) phase_len = 1;
      else if (roll < 70) phase_len = $urandom_range(8, 2);
      else if (roll < 82) phase_len = $urandom_range(63, 9);
      else if (roll < 91) phase_len = TABLE_DEPTH;
      else phase_len = $urandom_range(127, 65);
      rows = (phase_len > TABLE_DEPTH) ? TABLE_DEPTH : phase_len;
      source_calm = ($urandom_range(99) < 20);
      sink_calm   = ($urandom_range(99) < 20);

      // mostly descending voltages, some with repeats, a few unordered
      volt_pool.delete();
      repeat (rows) begin
        v = $urandom_range(VOLT_TOP);
        if ($urandom_range(2) == 0) v -= v % 1000;
        volt_pool.push_back(v);
      end
      style = $urandom_range(9);
      if (style != 0) volt_pool.rsort();
      if (style == 1 && rows > 1) begin
        idx = $urandom_range(rows - 1, 1);
        volt_pool[idx] = volt_pool[idx - 1];
      end
      for (int i = 0; i < int'(rows); i++) send_row(IDX_W'(i), VOLT_W'(volt_pool[i]));
      set_table_length(CFG_LEN_W'(phase_len));

      lookups = $urandom_range(40, 10);
      repeat (lookups) begin
        roll = $urandom_range(99);
        if (roll < 2) settle();
        if (roll >= 2 && roll < 10) begin
          send_row(IDX_W'($urandom_range(TABLE_DEPTH - 1)), VOLT_W'($urandom_range(VOLT_TOP)));
        end else begin
          roll = $urandom_range(99);
          if (rows != 0 && roll < 55)
            bus_mv = $urandom_range(volt_pool[0] / 1000, volt_pool[rows - 1] / 1000);
          else if (rows != 0 && roll < 70)
            bus_mv = volt_pool[$urandom_range(rows - 1)] / 1000;
          else
            bus_mv = $urandom_range(BUS_TOP);
          if (bus_mv > BUS_TOP) bus_mv = BUS_TOP;
          send_lookup(BUS_W'(bus_mv), SEL_W'($urandom_range(3)));
        end
      end
      phase++;
    end

    settle();
    $display("sent %0d row writes and %0d lookups across %0d table_length settings",
             rows_sent, lookups_sent, lengths_set);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
